### src/gm3_pkg.sv
// Shared constants, types and compare helpers for the grey 3x3 median filter.
`default_nettype none

package gm3_pkg;

	// Pixel and window geometry.
	localparam int GREY_W    = 8;
	localparam int WIN_SIDE  = 3;
	localparam int WIN_CELLS = WIN_SIDE * WIN_SIDE;

	// Line width register and counters.
	localparam int WIDTH_W = 13;
	localparam int POS_W   = 12;
	localparam int FILL_W  = 4;
	localparam logic [WIDTH_W-1:0] LINE_WIDTH_RESET = WIDTH_W'(512);
	localparam logic [WIDTH_W-1:0] LINE_WIDTH_MAX   = WIDTH_W'(4096);

	// Division by three as a multiply by a reciprocal; exact for sums up to 765.
	localparam int SUM_W       = 10;
	localparam int RECIP_3     = 683;
	localparam int RECIP_SHIFT = 11;
	localparam int PROD_W      = 20;

	// Default depth of the queue between the front and the back.
	localparam int FIFO_DEPTH_DEFAULT = 2;

	typedef logic [GREY_W-1:0] grey_t;

	// One complete window with the flag for the median it produces.
	typedef struct packed {
		grey_t [WIN_CELLS-1:0] cells;
		logic                  line_end;
	} win_item_t;

	// Queue status seen by both neighbors.
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// Three values in ascending order: [0] smallest, [2] largest.
	typedef grey_t [2:0] trio_t;

	function automatic trio_t sort3(input grey_t a, input grey_t b, input grey_t c);
		grey_t lo, hi, t;
		trio_t res;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		if (c < lo) begin
			res = {hi, lo, c};
		end else if (c < hi) begin
			res = {hi, c, lo};
		end else begin
			t = c;
			res = {t, hi, lo};
		end
		return res;
	endfunction

endpackage

`default_nettype wire

### src/gm3_ifs.sv
// Handshake channel interfaces: pixel input, median output, line width write.
`default_nettype none

interface gm3_pixel_if
	import gm3_pkg::*;
;
	logic        valid;
	logic        ready;
	grey_t       red;
	grey_t       green;
	grey_t       blue;

	modport source (output valid, red, green, blue, input ready);
	modport sink   (input valid, red, green, blue, output ready);
endinterface

interface gm3_median_if
	import gm3_pkg::*;
;
	logic        valid;
	logic        ready;
	grey_t       median;
	logic        line_end;

	modport source (output valid, median, line_end, input ready);
	modport sink   (input valid, median, line_end, output ready);
endinterface

interface gm3_cfg_if
	import gm3_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [WIDTH_W-1:0] line_width;

	modport source (output valid, line_width, input ready);
	modport sink   (input valid, line_width, output ready);
endinterface

`default_nettype wire

### src/gm3_front.sv
// Front end: grey conversion, window loading and line tracking.
`default_nettype none

module gm3_front
	import gm3_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	gm3_pixel_if.sink       pixel,
	gm3_cfg_if.sink         cfg,
	input  wire q_stat_t    q_stat,
	output logic            push,
	output win_item_t       push_item
);

	logic [WIDTH_W-1:0] width_q;
	grey_t              win_q [WIN_CELLS];
	logic [FILL_W-1:0]  fill_q;
	logic [POS_W-1:0]   linepos_q;

	grey_t              win_d [WIN_CELLS];
	logic [FILL_W-1:0]  fill_d;
	logic [POS_W-1:0]   linepos_d;
	logic [SUM_W-1:0]   sum;
	logic [PROD_W-1:0]  prod;
	grey_t              grey;
	logic               accept;
	logic               loading;
	logic               done;
	logic [1:0]         col_row;
	logic [WIDTH_W-1:0] eff_width;
	logic [WIDTH_W-1:0] pos_inc;
	logic               line_end;

	assign cfg.ready   = 1'b1;
	assign pixel.ready = !q_stat.full;
	assign accept      = pixel.valid && pixel.ready;

	// Grey value is the truncated mean of the three components.
	assign sum  = SUM_W'(pixel.red) + SUM_W'(pixel.green) + SUM_W'(pixel.blue);
	assign prod = PROD_W'(sum) * PROD_W'(RECIP_3);
	assign grey = prod[RECIP_SHIFT +: GREY_W];

	assign loading = (linepos_q == '0);
	assign col_row = fill_q[1:0];

	// Window update: row-major load at line start, else a new right column.
	always_comb begin
		win_d  = win_q;
		fill_d = fill_q;
		done   = 1'b0;
		if (loading) begin
			for (int i = 0; i < WIN_CELLS; i++) begin
				if (fill_q == FILL_W'(i)) begin
					win_d[i] = grey;
				end
			end
			if (fill_q == FILL_W'(WIN_CELLS - 1)) begin
				fill_d = '0;
				done   = 1'b1;
			end else begin
				fill_d = fill_q + FILL_W'(1);
			end
		end else begin
			if (col_row == 2'd0) begin
				for (int row = 0; row < WIN_SIDE; row++) begin
					for (int col = 0; col < WIN_SIDE - 1; col++) begin
						win_d[row*WIN_SIDE + col] = win_q[row*WIN_SIDE + col + 1];
					end
				end
			end
			for (int row = 0; row < WIN_SIDE; row++) begin
				if (col_row == 2'(row)) begin
					win_d[row*WIN_SIDE + WIN_SIDE - 1] = grey;
				end
			end
			if (col_row == 2'(WIN_SIDE - 1)) begin
				fill_d = '0;
				done   = 1'b1;
			end else begin
				fill_d = FILL_W'(col_row) + FILL_W'(1);
			end
		end
	end

	// Line end when this median's count reaches the clamped width.
	always_comb begin
		if (width_q == '0) begin
			eff_width = WIDTH_W'(1);
		end else if (width_q > LINE_WIDTH_MAX) begin
			eff_width = LINE_WIDTH_MAX;
		end else begin
			eff_width = width_q;
		end
		pos_inc  = WIDTH_W'(linepos_q) + WIDTH_W'(1);
		line_end = (pos_inc >= eff_width);
		if (done) begin
			linepos_d = line_end ? '0 : pos_inc[POS_W-1:0];
		end else begin
			linepos_d = linepos_q;
		end
	end

	// Completed window goes to the queue.
	assign push = accept && done;
	always_comb begin
		for (int i = 0; i < WIN_CELLS; i++) begin
			push_item.cells[i] = win_d[i];
		end
		push_item.line_end = line_end;
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= LINE_WIDTH_RESET;
			fill_q    <= '0;
			linepos_q <= '0;
			for (int i = 0; i < WIN_CELLS; i++) begin
				win_q[i] <= '0;
			end
		end else begin
			if (cfg.valid && cfg.ready) begin
				width_q <= cfg.line_width;
			end
			if (accept) begin
				fill_q    <= fill_d;
				linepos_q <= linepos_d;
				win_q     <= win_d;
			end
		end
	end

	// Load counter stays within the nine cells.
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < FILL_W'(WIN_CELLS))
		else $error("fill count beyond window size");

	// Outside a load the counter walks one column group only.
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		(linepos_q != '0) |-> (fill_q < FILL_W'(WIN_SIDE)))
		else $error("column counter out of range");

endmodule

`default_nettype wire

### src/gm3_queue.sv
// Short queue of completed windows between the front and the back.
`default_nettype none

module gm3_queue
	import gm3_pkg::*;
#(
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire win_item_t push_item,
	input  wire logic      pop,
	output win_item_t      pop_item,
	output q_stat_t        stat
);

	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	win_item_t          entries [FIFO_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign stat.full  = (count_q == CNT_W'(FIFO_DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign pop_item   = entries[rd_ptr_q];

	// Entry storage; payload needs no reset.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// The front never offers a window into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full)
		else $error("window pushed into full queue");

	// The back never pops an empty queue.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("pop from empty queue");

endmodule

`default_nettype wire

### src/gm3_back.sv
// Back end: two-stage median network with a held output register.
`default_nettype none

module gm3_back
	import gm3_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire q_stat_t   q_stat,
	input  wire win_item_t pop_item,
	output logic           pop,
	gm3_median_if.source   result
);

	trio_t  rows_d [WIN_SIDE];
	trio_t  rows_s1 [WIN_SIDE];
	logic   line_end_s1;
	logic   valid_s1;
	grey_t  median_s2;
	logic   line_end_s2;
	logic   valid_s2;

	trio_t  lo_set, mid_set, hi_set, final_set;
	logic   adv_s2;
	logic   adv_s1;

	// Each stage moves when it is empty or its successor moves.
	assign adv_s2 = !valid_s2 || result.ready;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign pop    = adv_s1 && !q_stat.empty;

	// Stage one: sort each row of the window.
	always_comb begin
		for (int row = 0; row < WIN_SIDE; row++) begin
			rows_d[row] = sort3(pop_item.cells[row*WIN_SIDE],
			                    pop_item.cells[row*WIN_SIDE + 1],
			                    pop_item.cells[row*WIN_SIDE + 2]);
		end
	end

	// Stage two: max of minima, median of medians, min of maxima, then their median.
	always_comb begin
		lo_set    = sort3(rows_s1[0][0], rows_s1[1][0], rows_s1[2][0]);
		mid_set   = sort3(rows_s1[0][1], rows_s1[1][1], rows_s1[2][1]);
		hi_set    = sort3(rows_s1[0][2], rows_s1[1][2], rows_s1[2][2]);
		final_set = sort3(lo_set[2], mid_set[1], hi_set[0]);
	end

	// Stage payload registers.
	always_ff @(posedge clk) begin
		if (adv_s1 && !q_stat.empty) begin
			rows_s1     <= rows_d;
			line_end_s1 <= pop_item.line_end;
		end
		if (adv_s2 && valid_s1) begin
			median_s2   <= final_set[1];
			line_end_s2 <= line_end_s1;
		end
	end

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= !q_stat.empty;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	assign result.valid    = valid_s2;
	assign result.median   = median_s2;
	assign result.line_end = line_end_s2;

endmodule

`default_nettype wire

### src/grey_median_3x3_sliding.sv
// Top level of the grey 3x3 sliding median filter.
//
//   channel  | dir | payload              | accepted when
//   ---------+-----+----------------------+-----------------------------
//   pixel    | in  | red, green, blue     | pixel.valid && pixel.ready
//   result   | out | median, line_end     | result.valid && result.ready
//   cfg      | in  | line_width           | cfg.valid (ready is always 1)
//
// One pixel is taken every cycle while the window queue has room.
// The window that a pixel completes is written into the queue, then passes through
// each of the two registered stages of the compare network before its median is
// valid on the result side.
// A stalled result side fills the queue, after which pixel.ready drops.
// Reset clears the window to zero, the counters, and sets line_width to 512.
`default_nettype none

module grey_median_3x3_sliding
	import gm3_pkg::*;
#(
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	gm3_pixel_if.sink    pixel,
	gm3_median_if.source result,
	gm3_cfg_if.sink      cfg
);

	q_stat_t   q_stat;
	logic      push;
	logic      pop;
	win_item_t push_item;
	win_item_t pop_item;

	gm3_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixel     (pixel),
		.cfg       (cfg),
		.q_stat    (q_stat),
		.push      (push),
		.push_item (push_item)
	);

	gm3_queue #(
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.stat      (q_stat)
	);

	gm3_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.pop_item (pop_item),
		.pop      (pop),
		.result   (result)
	);

endmodule

`default_nettype wire
